[src/cigar_text_parse_and_lengths_top_assert.svh]
// ----------------------------------------------------------------------------
// CIGAR parser assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef CIGAR_TEXT_PARSE_AND_LENGTHS_TOP_ASSERT_SVH
`define CIGAR_TEXT_PARSE_AND_LENGTHS_TOP_ASSERT_SVH

// Same-cycle implication, checked only while out of reset.
`define CTPL_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ctpl checker: same-cycle rule violated");

// Next-cycle implication, checked only while out of reset.
`define CTPL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ctpl checker: next-cycle rule violated");

`endif

[src/ctpl_pkg.sv]
// ----------------------------------------------------------------------------
// CIGAR parser package
// Types, character constants and codes shared by the CIGAR parser modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ctpl_pkg;

    // Width of run lengths and totals.
    localparam int LEN_BITS = 32;
    localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

    // Packed stream widths.
    localparam int OUT_FIELD_BITS = 8 + 3 * LEN_BITS + 3;
    localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

    // Characters of the CIGAR text.
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_EQ   = 8'h3D;
    localparam logic [7:0] CH_A    = 8'h41;
    localparam logic [7:0] CH_Z    = 8'h5A;
    localparam logic [7:0] CH_M    = 8'h4D;
    localparam logic [7:0] CH_I    = 8'h49;
    localparam logic [7:0] CH_D    = 8'h44;

    // Input item kinds.
    localparam logic FUNC_CHAR = 1'b0;
    localparam logic FUNC_END  = 1'b1;

    typedef enum logic [1:0] {
        KIND_RECORD = 2'd0,
        KIND_END    = 2'd1,
        KIND_ERROR  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ERR_NONE        = 3'd0,
        ERR_ZERO_LEN    = 3'd1,
        ERR_BAD_CHAR    = 3'd2,
        ERR_MISSING_OP  = 3'd3,
        ERR_UNSUPPORTED = 3'd4,
        ERR_OVERFLOW    = 3'd5
    } t_err;

    // One registered input item on its way into the parser.
    typedef struct packed {
        logic       valid;
        logic       func;
        logic [7:0] char_code;
    } t_step_in;

    // One result item.
    typedef struct packed {
        t_kind               kind;
        logic [7:0]          op_code;
        logic [LEN_BITS-1:0] run_length;
        logic [LEN_BITS-1:0] query_length;
        logic [LEN_BITS-1:0] ref_length;
        t_err                error_code;
        logic                last;
    } t_result;

endpackage

[src/ctpl_core.sv]
// ----------------------------------------------------------------------------
// CIGAR parser core
// Holds the parse state, handles one item per cycle unless stalled and registers the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctpl_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ctpl_pkg::t_step_in i_step,
    input  logic              i_strict,
    input  logic              i_out_ready,
    output logic              o_can_take,
    output logic              o_res_valid,
    output ctpl_pkg::t_result o_res
);

    localparam int LB = ctpl_pkg::LEN_BITS;

    logic [LB-1:0]       r_acc, n_acc;
    logic [LB-1:0]       r_qtot, n_qtot;
    logic [LB-1:0]       r_rtot, n_rtot;
    ctpl_pkg::t_err      r_held, n_held;
    logic                r_res_valid;
    ctpl_pkg::t_result   r_res, n_res;
    logic                res_fire;

    logic [LB+3:0]       acc_x10;
    logic [LB:0]         q_sum;
    logic [LB:0]         r_sum;
    logic                is_digit;
    logic                is_op;

    // Decimal step and total sums, all widened by the carry bits.
    assign acc_x10 = ({4'd0, r_acc} << 3) + ({4'd0, r_acc} << 1)
                   + {{LB{1'b0}}, i_step.char_code[3:0]};
    assign q_sum   = {1'b0, r_qtot} + {1'b0, r_acc};
    assign r_sum   = {1'b0, r_rtot} + {1'b0, r_acc};

    assign is_digit = i_step.char_code inside {[ctpl_pkg::CH_ZERO:ctpl_pkg::CH_NINE]};
    assign is_op    = i_step.char_code inside {[ctpl_pkg::CH_A:ctpl_pkg::CH_Z], ctpl_pkg::CH_EQ};

    assign o_can_take  = !r_res_valid || i_out_ready;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    // Next state and result for the item in the input register.
    always_comb begin
        logic ovf;
        ovf      = 1'b0;
        n_acc    = r_acc;
        n_qtot   = r_qtot;
        n_rtot   = r_rtot;
        n_held   = r_held;
        res_fire = 1'b0;
        n_res    = '{kind: ctpl_pkg::KIND_ERROR, op_code: 8'd0, run_length: r_acc,
                     query_length: r_qtot, ref_length: r_rtot,
                     error_code: ctpl_pkg::ERR_NONE, last: 1'b0};

        if (i_step.valid) begin
            if (i_step.func == ctpl_pkg::FUNC_END) begin
                // End of string: summary with the totals, then clear everything.
                res_fire         = 1'b1;
                n_res.kind       = ctpl_pkg::KIND_END;
                n_res.run_length = '0;
                n_res.last       = 1'b1;
                if (r_held == ctpl_pkg::ERR_NONE && r_acc != '0) begin
                    n_res.error_code = ctpl_pkg::ERR_MISSING_OP;
                end else begin
                    n_res.error_code = r_held;
                end
                n_acc  = '0;
                n_qtot = '0;
                n_rtot = '0;
                n_held = ctpl_pkg::ERR_NONE;
            end else if (r_held != ctpl_pkg::ERR_NONE) begin
                // Characters after an error are dropped.
                res_fire = 1'b0;
            end else if (is_digit) begin
                if (acc_x10[LB+3:LB] != 4'd0) begin
                    n_acc            = ctpl_pkg::LEN_MAX;
                    res_fire         = 1'b1;
                    n_res.run_length = ctpl_pkg::LEN_MAX;
                    n_res.error_code = ctpl_pkg::ERR_OVERFLOW;
                    n_held           = ctpl_pkg::ERR_OVERFLOW;
                end else begin
                    n_acc = acc_x10[LB-1:0];
                end
            end else if (is_op) begin
                res_fire = 1'b1;
                if (r_acc == '0) begin
                    n_res.error_code = ctpl_pkg::ERR_ZERO_LEN;
                    n_held           = ctpl_pkg::ERR_ZERO_LEN;
                end else begin
                    // Saturating total updates for the ops that count.
                    if (i_step.char_code == ctpl_pkg::CH_M ||
                        i_step.char_code == ctpl_pkg::CH_I) begin
                        n_qtot = q_sum[LB] ? ctpl_pkg::LEN_MAX : q_sum[LB-1:0];
                        ovf    = ovf | q_sum[LB];
                    end
                    if (i_step.char_code == ctpl_pkg::CH_M ||
                        i_step.char_code == ctpl_pkg::CH_D) begin
                        n_rtot = r_sum[LB] ? ctpl_pkg::LEN_MAX : r_sum[LB-1:0];
                        ovf    = ovf | r_sum[LB];
                    end
                    n_res.query_length = n_qtot;
                    n_res.ref_length   = n_rtot;
                    if (i_strict && !(i_step.char_code == ctpl_pkg::CH_M ||
                                      i_step.char_code == ctpl_pkg::CH_I ||
                                      i_step.char_code == ctpl_pkg::CH_D)) begin
                        n_res.error_code = ctpl_pkg::ERR_UNSUPPORTED;
                        n_held           = ctpl_pkg::ERR_UNSUPPORTED;
                    end else if (ovf) begin
                        n_res.error_code = ctpl_pkg::ERR_OVERFLOW;
                        n_held           = ctpl_pkg::ERR_OVERFLOW;
                    end else begin
                        n_res.kind    = ctpl_pkg::KIND_RECORD;
                        n_res.op_code = i_step.char_code;
                        n_acc         = '0;
                    end
                end
            end else begin
                res_fire         = 1'b1;
                n_res.error_code = ctpl_pkg::ERR_BAD_CHAR;
                n_held           = ctpl_pkg::ERR_BAD_CHAR;
            end
        end
    end

    // Parse state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_qtot <= '0;
            r_rtot <= '0;
            r_held <= ctpl_pkg::ERR_NONE;
        end else begin
            r_acc  <= n_acc;
            r_qtot <= n_qtot;
            r_rtot <= n_rtot;
            r_held <= n_held;
        end
    end

    // Result register; the top only presents an item when it can be taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (res_fire) begin
            r_res_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_fire) begin
            r_res <= n_res;
        end
    end

endmodule

[src/cigar_text_parse_and_lengths_top.sv]
// ----------------------------------------------------------------------------
// CIGAR text parser with query and reference lengths
// Parses CIGAR characters into op records, error reports and end summaries and keeps saturating length totals.
//
//   Channel  Direction  Handshake                      Payload
//   s_axis   in         s_axis_tvalid / s_axis_tready  tuser func, tdata char
//   m_axis   out        m_axis_tvalid / m_axis_tready  tuser kind, tdata, tlast
//   cfg      in         i_cfg_wr_en                    i_cfg_wr_data strict_ops
//
// One item is taken per cycle while s_axis_tready is high; an accepted item waits in
// the input register, and its result, if any, is presented from the result register.
// The input register and the result register each hold one item, so a stall
// on m_axis reaches s_axis_tready once both are full.
// Reset clears the parse state and both valid flags and sets strict_ops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cigar_text_parse_and_lengths_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic                                i_cfg_wr_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,  // char_code
    input  logic                                s_axis_tuser,  // func
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // op_code, run_length, query_length, ref_length, error_code, zero fill
    output logic [ctpl_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
    output logic [1:0]                          m_axis_tuser,  // kind
    output logic                                m_axis_tlast   // last
);

    localparam int PAD_BITS = ctpl_pkg::OUT_DATA_BITS - ctpl_pkg::OUT_FIELD_BITS;

    logic               r_strict;
    logic               r_in_valid;
    logic               r_in_func;
    logic [7:0]         r_in_char;
    logic               core_can_take;
    logic               advance;
    ctpl_pkg::t_step_in step;
    ctpl_pkg::t_result  res;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strict <= 1'b1;
        end else if (i_cfg_wr_en) begin
            r_strict <= i_cfg_wr_data;
        end
    end

    // Input register: moves into the core whenever the result slot is free.
    assign advance       = r_in_valid && core_can_take;
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_func <= s_axis_tuser;
            r_in_char <= s_axis_tdata;
        end
    end

    assign step = '{valid: advance, func: r_in_func, char_code: r_in_char};

    ctpl_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_strict    (r_strict),
        .i_out_ready (m_axis_tready),
        .o_can_take  (core_can_take),
        .o_res_valid (m_axis_tvalid),
        .o_res       (res)
    );

    // Pack the result fields, first field in the lowest bits.
    assign m_axis_tdata = {{PAD_BITS{1'b0}}, res.error_code, res.ref_length,
                           res.query_length, res.run_length, res.op_code};
    assign m_axis_tuser = res.kind;
    assign m_axis_tlast = res.last;

endmodule

[src/ctpl_checker.sv]
// ----------------------------------------------------------------------------
// CIGAR parser port checker
// Watches the top-level ports for result item consistency over time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "cigar_text_parse_and_lengths_top_assert.svh"

module ctpl_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_m_tvalid,
    input  logic                               i_m_tready,
    input  logic [ctpl_pkg::OUT_DATA_BITS-1:0] i_m_tdata,
    input  logic [1:0]                         i_m_tuser,
    input  logic                               i_m_tlast
);

    localparam int LB = ctpl_pkg::LEN_BITS;

    logic [7:0]    op_code;
    logic [LB-1:0] run_length;
    logic [2:0]    error_code;

    assign op_code    = i_m_tdata[7:0];
    assign run_length = i_m_tdata[8 +: LB];
    assign error_code = i_m_tdata[8 + 3 * LB +: 3];

    // A stalled result item holds.
    `CTPL_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser))

    // tlast marks exactly the end summary.
    `CTPL_ASSERT_NOW(a_last_is_end, i_clk, i_rst_n, i_m_tvalid, i_m_tlast == (i_m_tuser == ctpl_pkg::KIND_END))

    // A record carries a nonzero run, a nonzero op code and no error.
    `CTPL_ASSERT_NOW(a_record_sane, i_clk, i_rst_n, i_m_tvalid && i_m_tuser == ctpl_pkg::KIND_RECORD, run_length != '0 && error_code == ctpl_pkg::ERR_NONE && op_code != 8'd0)

    // An error report carries a code and no op.
    `CTPL_ASSERT_NOW(a_error_sane, i_clk, i_rst_n, i_m_tvalid && i_m_tuser == ctpl_pkg::KIND_ERROR, error_code != ctpl_pkg::ERR_NONE && op_code == 8'd0)

endmodule

bind cigar_text_parse_and_lengths_top ctpl_checker u_ctpl_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tuser  (m_axis_tuser),
    .i_m_tlast  (m_axis_tlast)
);

[test/testbench.sv]
// ----------------------------------------------------------------------------
// CIGAR text parser testbench
// Sends CIGAR characters and end items over the input stream and predicts
// every op record, error report and end summary with a cycle-free model of
// the parser. Each result item is compared field by field with the oldest
// prediction. Both stream sides idle and stall at random, and the receiver
// sometimes holds off long enough to back the parser up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    import ctpl_pkg::*;

    localparam int RESET_CYCLES = 11;
    localparam int QUIET_LIMIT  = 1000;
    localparam int PHASE_ITEMS  = 642;
    localparam int DRAIN_CYCLES = 4;
    localparam int MAX_PRINTS   = 50;

    // One character or end item as it travels on the input stream.
    typedef struct packed {
        logic       func;
        logic [7:0] char_code;
    } t_text_item;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_wr_en = 1'b0;
    logic                      i_cfg_wr_data = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [7:0]                s_axis_tdata = '0;   // char_code
    logic                      s_axis_tuser = 1'b0; // func
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    // op_code, run_length, query_length, ref_length, error_code, zero fill
    logic [OUT_DATA_BITS-1:0]  m_axis_tdata;
    logic [1:0]                m_axis_tuser;        // kind
    logic                      m_axis_tlast;        // last

    // Parser state as the testbench sees it.
    logic [LEN_BITS-1:0] run_digits;
    logic [LEN_BITS-1:0] query_total;
    logic [LEN_BITS-1:0] ref_total;
    t_err                held_err;
    logic                strict_mode;

    t_text_item text_queue[$];
    t_result    expected_results[$];
    int         item_count;
    int         mismatch_count;

    // Driver state.
    int         tx_gap;
    int         tx_calm;
    t_text_item tx_item;

    // Receiver state.
    int rx_hold;
    int rx_calm;
    int rx_seen;
    int rx_next_long_hold;

    // Checker state.
    bit      step_emits;
    t_result step_result;
    t_result want;
    int      quiet_cycles;

    cigar_text_parse_and_lengths_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Parser prediction
    // ------------------------------------------------------------------

    // Builds an error report from the current totals and holds the code.
    function automatic t_result error_report(t_err code);
        t_result res;
        held_err = code;
        res = '0;
        res.kind         = KIND_ERROR;
        res.run_length   = run_digits;
        res.query_length = query_total;
        res.ref_length   = ref_total;
        res.error_code   = code;
        return res;
    endfunction

    // Adds a run to one total, saturating. Returns 1 on saturation.
    function automatic bit add_saturating(ref logic [LEN_BITS-1:0] total,
                                          input logic [LEN_BITS-1:0] run);
        logic [LEN_BITS:0] sum;
        sum = {1'b0, total} + {1'b0, run};
        if (sum[LEN_BITS]) begin
            total = LEN_MAX;
            return 1'b1;
        end
        total = sum[LEN_BITS-1:0];
        return 1'b0;
    endfunction

    // Advances the parser by one accepted item and gives the result, if any.
    task automatic cigar_step(input logic func, input logic [7:0] ch,
                              output bit emits, output t_result res);
        logic [LEN_BITS+3:0] grown;
        bit                  ovf;
        bit                  ovf_ref;
        emits = 1'b0;
        res   = '0;
        ovf   = 1'b0;
        if (func == FUNC_END) begin
            // The summary carries the held error, or a dangling run of digits.
            res.kind         = KIND_END;
            res.query_length = query_total;
            res.ref_length   = ref_total;
            res.error_code   = held_err;
            if (held_err == ERR_NONE && run_digits != '0) begin
                res.error_code = ERR_MISSING_OP;
            end
            res.last   = 1'b1;
            emits      = 1'b1;
            run_digits = '0;
            query_total = '0;
            ref_total  = '0;
            held_err   = ERR_NONE;
        end else if (held_err != ERR_NONE) begin
            // Characters after an error are dropped until the end item.
            emits = 1'b0;
        end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
            grown = {4'b0, run_digits} * 10 + (ch - CH_ZERO);
            if (grown > {4'b0, LEN_MAX}) begin
                run_digits = LEN_MAX;
                res   = error_report(ERR_OVERFLOW);
                emits = 1'b1;
            end else begin
                run_digits = grown[LEN_BITS-1:0];
            end
        end else if ((ch >= CH_A && ch <= CH_Z) || ch == CH_EQ) begin
            emits = 1'b1;
            if (run_digits == '0) begin
                res = error_report(ERR_ZERO_LEN);
            end else if (ch != CH_M && ch != CH_I && ch != CH_D && strict_mode) begin
                res = error_report(ERR_UNSUPPORTED);
            end else begin
                // M feeds both totals; I only the query, D only the reference.
                if (ch == CH_M || ch == CH_I) begin
                    ovf = add_saturating(query_total, run_digits);
                end
                if (ch == CH_M || ch == CH_D) begin
                    ovf_ref = add_saturating(ref_total, run_digits);
                    ovf = ovf | ovf_ref;
                end
                if (ovf) begin
                    res = error_report(ERR_OVERFLOW);
                end else begin
                    res.kind         = KIND_RECORD;
                    res.op_code      = ch;
                    res.run_length   = run_digits;
                    res.query_length = query_total;
                    res.ref_length   = ref_total;
                    res.error_code   = ERR_NONE;
                    run_digits       = '0;
                end
            end
        end else begin
            res   = error_report(ERR_BAD_CHAR);
            emits = 1'b1;
        end
    endtask

    // ------------------------------------------------------------------
    // Reporting
    // ------------------------------------------------------------------

    task automatic report_mismatch(string what);
        if (mismatch_count < MAX_PRINTS) begin
            $display("ERROR at %0t ns: %s", $realtime, what);
        end
        mismatch_count++;
    endtask

    task automatic check_field(string name, logic [LEN_BITS-1:0] got,
                               logic [LEN_BITS-1:0] exp_val);
        if (got !== exp_val) begin
            report_mismatch($sformatf("%s is %0h, predicted %0h", name, got, exp_val));
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------

    // Appends one item at the tail of the pending queue.
    task automatic queue_item(logic func, logic [7:0] ch);
        t_text_item item;
        item.func      = func;
        item.char_code = ch;
        text_queue.insert(text_queue.size(), item);
        item_count++;
    endtask

    task automatic push_char(logic [7:0] ch);
        queue_item(FUNC_CHAR, ch);
    endtask

    task automatic push_text(string s);
        for (int k = 0; k < s.len(); k++) begin
            push_char(s[k]);
        end
    endtask

    // The character code is random on an end item; the parser ignores it.
    task automatic push_end();
        queue_item(FUNC_END, 8'($urandom));
    endtask

    // Digits for one run: mostly short lengths, some huge, some missing.
    task automatic push_run_length();
        int unsigned pick;
        int unsigned n;
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
            push_text($sformatf("%0d", $urandom_range(1, 999)));
        end else if (pick < 75) begin
            push_text($sformatf("%0d", $urandom_range(0, 9)));
        end else if (pick < 85) begin
            push_text($sformatf("%0d", $urandom));
        end else if (pick < 92) begin
            // Ten or eleven digits often overflow the accumulator.
            n = $urandom_range(10, 11);
            for (int k = 0; k < n; k++) begin
                push_char(CH_ZERO + 8'($urandom_range(0, 9)));
            end
        end else if (pick < 96) begin
            // No digits at all.
        end else begin
            push_text($sformatf("00%0d", $urandom_range(1, 99)));
        end
    endtask

    task automatic push_op();
        int unsigned pick;
        string       others;
        others = "SHNPX=";
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            case ($urandom_range(0, 2))
                0:       push_char(CH_M);
                1:       push_char(CH_I);
                default: push_char(CH_D);
            endcase
        end else if (pick < 82) begin
            push_char(others[$urandom_range(0, others.len() - 1)]);
        end else if (pick < 97) begin
            push_char(CH_A + 8'($urandom_range(0, 25)));
        end else begin
            push_char(8'($urandom));
        end
    endtask

    // One CIGAR string, mostly well formed, sometimes noise or cut short.
    task automatic push_random_cigar();
        int unsigned ops;
        if ($urandom_range(0, 99) < 8) begin
            repeat ($urandom_range(1, 6)) begin
                push_char(8'($urandom));
            end
            if ($urandom_range(0, 1) == 0) begin
                push_end();
            end
        end else begin
            ops = $urandom_range(0, 6);
            for (int k = 0; k < ops; k++) begin
                push_run_length();
                push_op();
            end
            // Trailing digits with no op now and then.
            if ($urandom_range(0, 99) < 4) begin
                push_run_length();
            end
            if ($urandom_range(0, 99) < 95) begin
                push_end();
            end
        end
    endtask

    // Waits until every item is sent and every result has arrived, then
    // lets the pipeline settle in case the last items gave no result.
    task automatic wait_idle();
        do begin
            @(negedge i_clk);
        end while (text_queue.size() != 0 || s_axis_tvalid
                   || expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_strict(logic value);
        wait_idle();
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        strict_mode    = value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    task automatic run_random_phase();
        int target;
        target = item_count + PHASE_ITEMS;
        while (item_count < target) begin
            push_random_cigar();
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin
        run_digits     = '0;
        query_total    = '0;
        ref_total      = '0;
        held_err       = ERR_NONE;
        strict_mode    = 1'b1;
        item_count     = 0;
        mismatch_count = 0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed strings in strict mode, as after reset.
        push_text("90M1I2D");
        push_end();
        push_text("M5");          // op with no digits, then a dropped digit
        push_end();
        push_text("0A");          // digits that add up to zero
        push_end();
        push_char(8'h00);         // lowest character code
        push_end();
        push_char(8'hFF);         // highest character code
        push_end();
        push_text("7");           // digits left at the end
        push_end();
        push_text("3Z");          // unsupported op in strict mode
        push_end();
        push_text("1=");
        push_end();

        write_strict(1'b0);
        run_random_phase();
        write_strict(1'b1);
        run_random_phase();
        write_strict(1'b0);
        run_random_phase();

        wait_idle();
        if (expected_results.size() != 0) begin
            report_mismatch("predicted results never arrived");
        end
        if (mismatch_count == 0) begin
            $display("cigar_text_parse_and_lengths_top: match");
        end else begin
            $display("cigar_text_parse_and_lengths_top: mismatch");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Input driver: random gaps between items, with calm stretches.
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            tx_gap  = 0;
            tx_calm = 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (tx_gap > 0) begin
                tx_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (text_queue.size() != 0) begin
                tx_item = text_queue.pop_front();
                s_axis_tdata  <= tx_item.char_code;
                s_axis_tuser  <= tx_item.func;
                s_axis_tvalid <= 1'b1;
                // Pick the gap before the next item.
                if (tx_calm > 0) begin
                    tx_calm--;
                    tx_gap = 0;
                end else if ($urandom_range(0, 149) == 0) begin
                    tx_calm = $urandom_range(50, 150);
                    tx_gap  = 0;
                end else begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4, 5: tx_gap = 0;
                        6, 7, 8:          tx_gap = $urandom_range(1, 3);
                        default:          tx_gap = $urandom_range(4, 40);
                    endcase
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output receiver: short random stalls, calm stretches, and now and
    // then a long hold-off that backs the parser up into its input.
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_hold = 0;
            rx_calm = 0;
            rx_seen = 0;
            rx_next_long_hold = 40;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                rx_seen++;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                m_axis_tready <= 1'b0;
            end else if (rx_seen >= rx_next_long_hold) begin
                rx_hold = $urandom_range(60, 120) - 1;
                rx_next_long_hold = rx_seen + $urandom_range(300, 600);
                m_axis_tready <= 1'b0;
            end else if (rx_calm > 0) begin
                rx_calm--;
                m_axis_tready <= 1'b1;
            end else begin
                case ($urandom_range(0, 99)) inside
                    [0:2]:   begin
                        rx_calm = $urandom_range(40, 120);
                        m_axis_tready <= 1'b1;
                    end
                    [3:69]:  m_axis_tready <= 1'b1;
                    [70:94]: begin
                        rx_hold = $urandom_range(1, 3) - 1;
                        m_axis_tready <= 1'b0;
                    end
                    default: begin
                        rx_hold = $urandom_range(8, 30) - 1;
                        m_axis_tready <= 1'b0;
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Prediction on each accepted item, check on each accepted result.
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                cigar_step(s_axis_tuser, s_axis_tdata, step_emits, step_result);
                if (step_emits) begin
                    expected_results.insert(expected_results.size(), step_result);
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result item with no prediction waiting");
                end else begin
                    want = expected_results.pop_front();
                    check_field("kind", m_axis_tuser, want.kind);
                    check_field("op_code", m_axis_tdata[7:0], want.op_code);
                    check_field("run_length", m_axis_tdata[8 +: LEN_BITS],
                                want.run_length);
                    check_field("query_length", m_axis_tdata[8 + LEN_BITS +: LEN_BITS],
                                want.query_length);
                    check_field("ref_length", m_axis_tdata[8 + 2 * LEN_BITS +: LEN_BITS],
                                want.ref_length);
                    check_field("error_code", m_axis_tdata[8 + 3 * LEN_BITS +: 3],
                                want.error_code);
                    check_field("last", m_axis_tlast, want.last);
                end
            end
        end
    end

    // Watchdog: too many cycles with no item moving on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready)
            || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("ERROR at %0t ns: no item moved for %0d cycles",
                         $realtime, QUIET_LIMIT);
                $display("cigar_text_parse_and_lengths_top: mismatch");
                $finish;
            end
        end
    end

endmodule

[sim.f]
+incdir+src
src/ctpl_pkg.sv
src/ctpl_core.sv
src/cigar_text_parse_and_lengths_top.sv
src/ctpl_checker.sv
test/testbench.sv
